FILE: sv/chlg_pkg.sv
// ----------------------------------------------------------------------------
// chlg_pkg
// Shared types, constants and a helper function of the core hotplug load
// governor: tick and command layouts, register indexes, score limits.
// ----------------------------------------------------------------------------
package chlg_pkg;

    // field widths
    localparam int LOAD_W   = 7;
    localparam int COUNT_W  = 3;
    localparam int HOLD_W   = 16;
    localparam int TIME_W   = 32;
    localparam int SCORE_W  = 5;

    // stream widths (tdata padded to whole bytes)
    localparam int TICK_BITS = 2 * LOAD_W + 3 + COUNT_W + 2 + TIME_W;
    localparam int IN_DATA_W = ((TICK_BITS + 7) / 8) * 8;
    localparam int CMD_BITS  = 4;
    localparam int OUT_DATA_W = ((CMD_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HOLD_W;

    localparam logic [CFG_IDX_W-1:0] REG_LOAD_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_CORE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HOLD_MS      = 2'd2;

    localparam logic [LOAD_W-1:0]  LOAD_THRESHOLD_RST   = 7'd60;
    localparam logic [COUNT_W-1:0] TOUCH_CORE_COUNT_RST = 3'd2;
    localparam logic [HOLD_W-1:0]  MIN_HOLD_MS_RST      = 16'd1000;

    // score limits
    localparam logic [SCORE_W-1:0] SCORE_CAP   = 5'd20;
    localparam logic [SCORE_W-1:0] SCORE_RAISE = 5'd10;
    localparam logic [SCORE_W-1:0] SCORE_MAX   = 5'd21;
    localparam logic [SCORE_W-1:0] SCORE_STEP  = 5'd2;

    // core numbers that touch boost compares against
    localparam logic [COUNT_W-1:0] CORE2_NUM = 3'd2;
    localparam logic [COUNT_W-1:0] CORE3_NUM = 3'd3;

    // one governor tick
    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic               boost_policy;
        logic               touching;
        logic [COUNT_W-1:0] online_count;
        logic               core3_online;
        logic               core2_online;
        logic               core1_online;
        logic [LOAD_W-1:0]  load_core1;
        logic [LOAD_W-1:0]  load_core0;
    } tick_t;

    // hotplug commands of one tick
    typedef struct packed {
        logic core3_down;
        logic core3_up;
        logic core2_down;
        logic core2_up;
    } cmd_t;

    // score update: up by two below the cap on high load, else down toward zero
    function automatic logic [SCORE_W-1:0] next_score(
        input logic [SCORE_W-1:0] score,
        input logic [LOAD_W-1:0]  load,
        input logic [LOAD_W-1:0]  threshold
    );
        logic [SCORE_W-1:0] res;
        res = score;
        if (load >= threshold) begin
            if (score < SCORE_CAP) begin
                res = score + SCORE_STEP;
            end
        end else if (score != '0) begin
            res = score - SCORE_W'(1);
        end
        return res;
    endfunction

endpackage

FILE: sv/core_hotplug_load_governor.sv
// ----------------------------------------------------------------------------
// core_hotplug_load_governor
// Per-tick hotplug decisions for cores 2 and 3 from load scores of cores 0
// and 1, with touch boost and a minimum hold time.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one governor tick per transfer (loads, online flags,
//   online count, touch and policy flags, millisecond time). m_axis_* returns
//   one command transfer per tick with the up/down flags of cores 2 and 3.
//   cfg_wr_en/cfg_index/cfg_data write the threshold, touch core count and
//   hold time; write them only while no tick is in flight.
//   A tick goes from the accepting edge into one input register, then
//   through the score and steer logic into the output register, which
//   presents the command. Throughput is one tick per cycle; the input
//   register and the output register each advance whenever the next stage
//   has room, so a tick is accepted even while a command waits.
//   When the receiver stalls, the command holds in the output register and
//   at most one more tick waits in the input register before s_axis_tready
//   drops. Scores and time stamps advance only when a tick moves into the
//   output register.
//   Reset clears the scores and stamps, loads the register defaults
//   (threshold 60, touch count 2, hold 1000 ms) and empties both registers.
// ----------------------------------------------------------------------------
module core_hotplug_load_governor (
    input  logic                               clk,
    input  logic                               rst_n,
    // tick in: load_core0, load_core1, core1_online, core2_online,
    // core3_online, online_count, touching, boost_policy, now_ms, zero pad
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [chlg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command out: core2_up, core2_down, core3_up, core3_down, zero pad
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [chlg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // register writes
    input  logic                               cfg_wr_en,
    input  logic [chlg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [chlg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import chlg_pkg::*;

    // configuration registers
    logic [LOAD_W-1:0]  load_threshold_reg;
    logic [COUNT_W-1:0] touch_core_count_reg;
    logic [HOLD_W-1:0]  min_hold_ms_reg;

    // pipeline registers
    logic               in_valid_reg;
    tick_t              tick_reg;
    logic               out_valid_reg;
    cmd_t               cmd_reg;

    // governor state
    logic [SCORE_W-1:0] score_core0_reg, score_core0_next;
    logic [SCORE_W-1:0] score_core1_reg, score_core1_next;
    logic [TIME_W-1:0]  raised_at_core2_reg, raised_at_core2_next;
    logic [TIME_W-1:0]  raised_at_core3_reg, raised_at_core3_next;

    logic               in_take;
    logic               advance;
    logic               boost;
    logic               c2_on;
    logic               c3_on;
    logic [TIME_W-1:0]  elapsed2;
    logic [TIME_W-1:0]  elapsed3;
    cmd_t               cmd_next;

    // handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CMD_BITS){1'b0}}, cmd_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_threshold_reg   <= LOAD_THRESHOLD_RST;
            touch_core_count_reg <= TOUCH_CORE_COUNT_RST;
            min_hold_ms_reg      <= MIN_HOLD_MS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LOAD_THRESHOLD:   load_threshold_reg   <= cfg_data[LOAD_W-1:0];
                REG_TOUCH_CORE_COUNT: touch_core_count_reg <= cfg_data[COUNT_W-1:0];
                REG_MIN_HOLD_MS:      min_hold_ms_reg      <= cfg_data[HOLD_W-1:0];
                default:              ;
            endcase
        end
    end

    // touch boost raises offline extra cores below the touch core count
    always_comb
    begin
        boost = tick_reg.boost_policy && tick_reg.touching
                && (tick_reg.online_count < touch_core_count_reg);
        cmd_next = '0;
        c2_on = tick_reg.core2_online;
        c3_on = tick_reg.core3_online;
        if (boost && (touch_core_count_reg > CORE2_NUM) && !tick_reg.core2_online)
        begin
            cmd_next.core2_up = 1'b1;
            c2_on = 1'b1;
        end
        if (boost && (touch_core_count_reg > CORE3_NUM) && !tick_reg.core3_online)
        begin
            cmd_next.core3_up = 1'b1;
            c3_on = 1'b1;
        end

        // score update
        score_core0_next = next_score(score_core0_reg, tick_reg.load_core0,
                                      load_threshold_reg);
        score_core1_next = score_core1_reg;
        if (tick_reg.core1_online)
        begin
            score_core1_next = next_score(score_core1_reg, tick_reg.load_core1,
                                          load_threshold_reg);
        end

        // steer core 2 from score 0
        elapsed2 = tick_reg.now_ms - raised_at_core2_reg;
        raised_at_core2_next = raised_at_core2_reg;
        if (score_core0_next >= SCORE_RAISE)
        begin
            if (!c2_on)
            begin
                cmd_next.core2_up = 1'b1;
                raised_at_core2_next = tick_reg.now_ms;
            end
        end
        else if (c2_on && (elapsed2 > {{(TIME_W - HOLD_W){1'b0}}, min_hold_ms_reg}))
        begin
            cmd_next.core2_down = 1'b1;
        end

        // steer core 3 from score 1
        elapsed3 = tick_reg.now_ms - raised_at_core3_reg;
        raised_at_core3_next = raised_at_core3_reg;
        if (score_core1_next >= SCORE_RAISE)
        begin
            if (!c3_on)
            begin
                cmd_next.core3_up = 1'b1;
                raised_at_core3_next = tick_reg.now_ms;
            end
        end
        else if (c3_on && (elapsed3 > {{(TIME_W - HOLD_W){1'b0}}, min_hold_ms_reg}))
        begin
            cmd_next.core3_down = 1'b1;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg <= tick_t'(s_axis_tdata[TICK_BITS-1:0]);
        end
    end

    // output register and state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            score_core0_reg     <= '0;
            score_core1_reg     <= '0;
            raised_at_core2_reg <= '0;
            raised_at_core3_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg       <= 1'b1;
            score_core0_reg     <= score_core0_next;
            score_core1_reg     <= score_core1_next;
            raised_at_core2_reg <= raised_at_core2_next;
            raised_at_core3_reg <= raised_at_core3_next;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg <= cmd_next;
        end
    end

    // checks
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        (score_core0_reg <= SCORE_MAX) && (score_core1_reg <= SCORE_MAX))
        else $error("load score out of range");

    a_stall_holds_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_core1_offline_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !tick_reg.core1_online) |=> $stable(score_core1_reg))
        else $error("core 1 score changed while core 1 offline");

    a_core2_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (score_core0_next >= SCORE_RAISE) && !c2_on)
        |=> (raised_at_core2_reg == $past(tick_reg.now_ms)) && cmd_reg.core2_up)
        else $error("core 2 raise not stamped");

endmodule
